// ===== rtl/core/imvc_pkg.sv =====
// Shared types and constants for the induction motor vector control step block.
// No dependencies; imported by every module of the block except the checker.
`timescale 1ns / 1ps
`default_nettype none

package imvc_pkg;

  // Handshake status of a multicycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } imvc_unit_stat_t;

  // Field-weakening speed band of the speed reference.
  typedef logic [1:0] imvc_region_t;
  localparam imvc_region_t REGION_BASE = 2'd0;
  localparam imvc_region_t REGION_LOW  = 2'd1;
  localparam imvc_region_t REGION_MID  = 2'd2;
  localparam imvc_region_t REGION_HIGH = 2'd3;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  typedef logic [CFG_ADDR_W-1:0] imvc_cfg_addr_t;
  localparam imvc_cfg_addr_t CFG_PROP_GAIN  = 3'd0;
  localparam imvc_cfg_addr_t CFG_INT_GAIN   = 3'd1;
  localparam imvc_cfg_addr_t CFG_PERIOD     = 3'd2;
  localparam imvc_cfg_addr_t CFG_LM         = 3'd3;
  localparam imvc_cfg_addr_t CFG_LR         = 3'd4;
  localparam imvc_cfg_addr_t CFG_TAU_R      = 3'd5;
  localparam imvc_cfg_addr_t CFG_TORQUE_LIM = 3'd6;
  localparam imvc_cfg_addr_t CFG_RATED_FLUX = 3'd7;

  // Converts a Q32 constant to the block's format, rounded to nearest and
  // saturated to the positive range of a dw-bit signed value.
  function automatic logic [63:0] from_q32(input logic [63:0] q, input int dw, input int fb);
    logic [127:0] m;
    logic [127:0] lim;
    lim = (128'd1 << (dw - 1)) - 128'd1;
    if (fb >= 32) m = {64'd0, q} << (fb - 32);
    else m = ({64'd0, q} + (128'd1 << (31 - fb))) >> (32 - fb);
    if (m > lim) m = lim;
    return m[63:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/induction_motor_vector_control_step_top.sv =====
// Induction motor indirect rotor-flux-oriented vector control step, top level.
// Depends on imvc_pkg, imvc_front and imvc_back.
//
// Usage:
//   Input is a queue: drive the sample on in_* and raise in_push; the sample
//   transfers on a clock edge with in_push high and in_full low. Two samples
//   can wait ahead of the one being computed.
//   Output is a queue: while out_empty is low the oldest result sits on the
//   out_* ports and transfers on an edge with out_pop high.
//   Each sample takes one pass of a step sequencer over one shared multiplier
//   (13 products, 11 in the base speed band) and one shared divider (three
//   quotients), with one sample in flight at a time: the next sample starts
//   only once the current one has finished.
//   A finished result waits in the output register; while it is not popped
//   the next sample is still computed and then holds until the slot frees.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at the
//   edge and belong to idle periods. Synchronous reset restores the default
//   gains and clears the integrators, the flux estimate and both queues.
`timescale 1ns / 1ps
`default_nettype none

module induction_motor_vector_control_step_top #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  imvc_pkg::imvc_cfg_addr_t     cfg_addr,
  input  logic [DATA_WIDTH-2:0]        cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [DATA_WIDTH-1:0] in_id_measured,
  input  logic signed [DATA_WIDTH-1:0] in_iq_measured,
  input  logic signed [DATA_WIDTH-1:0] in_speed_measured,
  input  logic signed [DATA_WIDTH-1:0] in_speed_target,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [DATA_WIDTH-1:0] out_id_command,
  output logic signed [DATA_WIDTH-1:0] out_iq_command,
  output logic signed [DATA_WIDTH-1:0] out_torque_command,
  output logic signed [DATA_WIDTH-1:0] out_rotor_flux_out
);
  import imvc_pkg::*;

  logic                         item_valid, item_pop;
  logic signed [DATA_WIDTH-1:0] item_id, item_tgt, item_err;
  imvc_region_t                 item_region;
  logic                         iq_unused;

  // q-axis current measurement has no role in this control law
  assign iq_unused = ^in_iq_measured;

  imvc_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_id_measured    (in_id_measured),
    .in_speed_measured (in_speed_measured),
    .in_speed_target   (in_speed_target),
    .item_valid        (item_valid),
    .item_pop          (item_pop),
    .item_id           (item_id),
    .item_tgt          (item_tgt),
    .item_err          (item_err),
    .item_region       (item_region)
  );

  imvc_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .item_valid         (item_valid),
    .item_pop           (item_pop),
    .item_id            (item_id),
    .item_tgt           (item_tgt),
    .item_err           (item_err),
    .item_region        (item_region),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_id_command     (out_id_command),
    .out_iq_command     (out_iq_command),
    .out_torque_command (out_torque_command),
    .out_rotor_flux_out (out_rotor_flux_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/imvc_front.sv =====
// Front end: takes input samples, forms the speed error and the field-weakening
// band, and holds them in a two-entry queue. Depends on imvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imvc_front #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [DATA_WIDTH-1:0] in_id_measured,
  input  logic signed [DATA_WIDTH-1:0] in_speed_measured,
  input  logic signed [DATA_WIDTH-1:0] in_speed_target,
  output logic                         item_valid,
  input  logic                         item_pop,
  output logic signed [DATA_WIDTH-1:0] item_id,
  output logic signed [DATA_WIDTH-1:0] item_tgt,
  output logic signed [DATA_WIDTH-1:0] item_err,
  output imvc_pkg::imvc_region_t       item_region
);
  import imvc_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] S2000 = W'(from_q32(64'd8589934592000, W, FRAC_BITS));
  localparam logic signed [W-1:0] S2500 = W'(from_q32(64'd10737418240000, W, FRAC_BITS));
  localparam logic signed [W-1:0] S3000 = W'(from_q32(64'd12884901888000, W, FRAC_BITS));

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  logic signed [W-1:0] id_q_r  [2];
  logic signed [W-1:0] tgt_q_r [2];
  logic signed [W-1:0] err_q_r [2];
  imvc_region_t        reg_q_r [2];
  logic                wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pop;
  imvc_region_t        region;

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign push       = in_push && !in_full;
  assign pop        = item_pop && item_valid;

  always_comb begin
    if (in_speed_target <= S2000) region = REGION_BASE;
    else if (in_speed_target <= S2500) region = REGION_LOW;
    else if (in_speed_target <= S3000) region = REGION_MID;
    else region = REGION_HIGH;
  end

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      id_q_r[wr_r]  <= in_id_measured;
      tgt_q_r[wr_r] <= in_speed_target;
      err_q_r[wr_r] <= sub_s(in_speed_target, in_speed_measured);
      reg_q_r[wr_r] <= region;
    end
  end

  assign item_id     = id_q_r[rd_r];
  assign item_tgt    = tgt_q_r[rd_r];
  assign item_err    = err_q_r[rd_r];
  assign item_region = reg_q_r[rd_r];

endmodule

`default_nettype wire

// ===== rtl/core/imvc_mul.sv =====
// Shared fixed-point multiplier, four multiplier bits per cycle, with
// round-to-nearest and saturation as a final step. Depends on imvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imvc_mul #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  output logic signed [DATA_WIDTH-1:0] res,
  output imvc_pkg::imvc_unit_stat_t    stat
);
  import imvc_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int WP  = ((W + 3) / 4) * 4;
  localparam int NST = WP / 4;
  localparam int CW  = $clog2(NST + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]      ua, ub;
  logic [WP-1:0]     x_r;
  logic [2*WP-1:0]   p_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r, neg_r;
  logic signed [W-1:0] res_r;
  logic [WP+3:0]     sum;
  logic [2*WP:0]     rnd, m;
  logic              ov;
  logic signed [W-1:0] fin;

  assign ua = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign ub = op_b[W-1] ? (~op_b + 1'b1) : op_b;

  // Hi half stays below x, so the partial sum fits WP+4 bits.
  assign sum = {4'd0, p_r[2*WP-1:WP]} + x_r * p_r[3:0];
  assign rnd = {1'b0, p_r} + ((2*WP+1)'(1) << (FRAC_BITS - 1));
  assign m   = rnd >> FRAC_BITS;
  assign ov  = (m >> (W - 1)) != '0;

  always_comb begin
    if (ov) fin = neg_r ? VMIN : VMAX;
    else if (neg_r) fin = ~m[W-1:0] + 1'b1;
    else fin = m[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(NST);
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      x_r   <= WP'(ua);
      p_r   <= {{WP{1'b0}}, WP'(ub)};
      neg_r <= op_a[W-1] ^ op_b[W-1];
    end else if (busy_r && cnt_r != '0) begin
      p_r <= {sum, p_r[WP-1:4]};
    end else if (busy_r) begin
      res_r <= fin;
    end
  end

  assign res       = res_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/imvc_div.sv =====
// Shared fixed-point divider: restoring, one quotient bit per cycle, then
// round-to-nearest and saturation. Depends on imvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imvc_div #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  output logic signed [DATA_WIDTH-1:0] res,
  output imvc_pkg::imvc_unit_stat_t    stat
);
  import imvc_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  ua, ub;
  logic [NW-1:0] n_r, q_r;
  logic [W-1:0]  rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r, neg_r, asgn_r, azero_r, dz_r;
  logic signed [W-1:0] res_r;
  logic [W:0]    rem2, diff;
  logic          ge, up, ov;
  logic [NW:0]   qr;
  logic signed [W-1:0] fin;

  assign ua = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign ub = op_b[W-1] ? (~op_b + 1'b1) : op_b;

  assign rem2 = {rem_r, n_r[NW-1]};
  assign diff = rem2 - {1'b0, d_r};
  assign ge   = rem2 >= {1'b0, d_r};
  assign up   = {rem_r, 1'b0} >= {1'b0, d_r};
  assign qr   = {1'b0, q_r} + {{NW{1'b0}}, up};
  assign ov   = (qr >> (W - 1)) != '0;

  always_comb begin
    if (dz_r) begin
      if (azero_r) fin = '0;
      else fin = asgn_r ? VMIN : VMAX;
    end else if (ov) fin = neg_r ? VMIN : VMAX;
    else if (neg_r) fin = ~qr[W-1:0] + 1'b1;
    else fin = qr[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          // zero divisor skips the iteration
          cnt_r  <= (ub == '0) ? '0 : CW'(NW);
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      n_r     <= {ua, {FRAC_BITS{1'b0}}};
      d_r     <= ub;
      q_r     <= '0;
      rem_r   <= '0;
      neg_r   <= op_a[W-1] ^ op_b[W-1];
      asgn_r  <= op_a[W-1];
      azero_r <= (ua == '0);
      dz_r    <= (ub == '0);
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? diff[W-1:0] : rem2[W-1:0];
      q_r   <= {q_r[NW-2:0], ge};
      n_r   <= {n_r[NW-2:0], 1'b0};
    end else if (busy_r) begin
      res_r <= fin;
    end
  end

  assign res       = res_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/imvc_back.sv =====
// Back end: configuration registers, loop state and the step sequencer that
// runs the control law on the shared multiplier and divider, plus the result
// register. Depends on imvc_pkg, imvc_mul and imvc_div.
`timescale 1ns / 1ps
`default_nettype none

module imvc_back #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  imvc_pkg::imvc_cfg_addr_t     cfg_addr,
  input  logic [DATA_WIDTH-2:0]        cfg_wdata,
  input  logic                         item_valid,
  output logic                         item_pop,
  input  logic signed [DATA_WIDTH-1:0] item_id,
  input  logic signed [DATA_WIDTH-1:0] item_tgt,
  input  logic signed [DATA_WIDTH-1:0] item_err,
  input  imvc_pkg::imvc_region_t       item_region,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [DATA_WIDTH-1:0] out_id_command,
  output logic signed [DATA_WIDTH-1:0] out_iq_command,
  output logic signed [DATA_WIDTH-1:0] out_torque_command,
  output logic signed [DATA_WIDTH-1:0] out_rotor_flux_out
);
  import imvc_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] LIM15 = W'(from_q32(64'd64424509440, W, F));
  localparam logic signed [W-1:0] LIM2  = W'(from_q32(64'd8589934592, W, F));
  localparam logic signed [W-1:0] LIM1  = W'(from_q32(64'd4294967296, W, F));
  localparam logic signed [W-1:0] K12   = W'(from_q32(64'd51539607552, W, F));
  localparam logic signed [W-1:0] FMIN  = W'(from_q32(64'd4294967, W, F));
  localparam logic signed [W-1:0] A_LOW  = W'(from_q32(64'd858993, W, F));
  localparam logic signed [W-1:0] B_LOW  = W'(from_q32(64'd6012954214, W, F));
  localparam logic signed [W-1:0] A_MID  = W'(from_q32(64'd1546188, W, F));
  localparam logic signed [W-1:0] B_MID  = W'(from_q32(64'd7730941133, W, F));
  localparam logic signed [W-1:0] A_HIGH = W'(from_q32(64'd1803886, W, F));
  localparam logic signed [W-1:0] B_HIGH = W'(from_q32(64'd8504035246, W, F));

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [3:0] SP_KIDT    = 4'd0;
  localparam logic [3:0] SP_SINT    = 4'd1;
  localparam logic [3:0] SP_TORQUE  = 4'd2;
  localparam logic [3:0] SP_FW_A    = 4'd3;
  localparam logic [3:0] SP_FW_REF  = 4'd4;
  localparam logic [3:0] SP_TAU_PHI = 4'd5;
  localparam logic [3:0] SP_DT_LM   = 4'd6;
  localparam logic [3:0] SP_ID_TERM = 4'd7;
  localparam logic [3:0] SP_FLUX    = 4'd8;
  localparam logic [3:0] SP_IQ_NUM  = 4'd9;
  localparam logic [3:0] SP_LM12    = 4'd10;
  localparam logic [3:0] SP_IQ_DEN  = 4'd11;
  localparam logic [3:0] SP_IQ      = 4'd12;
  localparam logic [3:0] SP_FINT    = 4'd13;
  localparam logic [3:0] SP_FSUM    = 4'd14;
  localparam logic [3:0] SP_IDC     = 4'd15;

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clamp_sym(input logic signed [W-1:0] v,
                                                    input logic signed [W-1:0] lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  // configuration
  logic [W-2:0] kp_r, ki_r, dt_r, lm_r, lr_r, tau_r, tlim_r, nf_r;
  // loop state
  logic signed [W-1:0] sint_r, fint_r, rflux_r;
  // per-item working registers
  logic signed [W-1:0] id_r, tgt_r, err_r, kidt_r, torque_r, fref_r, flux_r, iq_r;
  logic signed [W-1:0] tmp_r, tmp2_r;
  imvc_region_t        region_r;
  logic [1:0]          state_r, state_nxt;
  logic [3:0]          step_r, step_nxt;
  logic                out_valid_r;
  logic signed [W-1:0] o_id_r, o_iq_r, o_tq_r, o_fl_r;

  logic signed [W-1:0] kp, ki, dt, lm, lr, tau, tlim, nf;
  logic signed [W-1:0] op_a, op_b, coef_a, coef_b, flux_fl, res;
  logic signed [W-1:0] mul_res, div_res;
  imvc_unit_stat_t     mul_stat, div_stat;
  logic                is_div, unit_done, out_free;

  assign kp   = {1'b0, kp_r};
  assign ki   = {1'b0, ki_r};
  assign dt   = {1'b0, dt_r};
  assign lm   = {1'b0, lm_r};
  assign lr   = {1'b0, lr_r};
  assign tau  = {1'b0, tau_r};
  assign tlim = {1'b0, tlim_r};
  assign nf   = {1'b0, nf_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= (W-1)'(from_q32(64'd171798691840, W, F));
      ki_r   <= (W-1)'(from_q32(64'd214748364800, W, F));
      dt_r   <= (W-1)'(from_q32(64'd214748, W, F));
      lm_r   <= (W-1)'(from_q32(64'd3477205523, W, F));
      lr_r   <= (W-1)'(from_q32(64'd3615288721, W, F));
      tau_r  <= (W-1)'(from_q32(64'd446331941, W, F));
      tlim_r <= (W-1)'(from_q32(64'd128849018880, W, F));
      nf_r   <= (W-1)'(from_q32(64'd1288490189, W, F));
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PROP_GAIN:  kp_r   <= cfg_wdata;
        CFG_INT_GAIN:   ki_r   <= cfg_wdata;
        CFG_PERIOD:     dt_r   <= cfg_wdata;
        CFG_LM:         lm_r   <= cfg_wdata;
        CFG_LR:         lr_r   <= cfg_wdata;
        CFG_TAU_R:      tau_r  <= cfg_wdata;
        CFG_TORQUE_LIM: tlim_r <= cfg_wdata;
        CFG_RATED_FLUX: nf_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (region_r)
      REGION_LOW: begin coef_a = A_LOW; coef_b = B_LOW; end
      REGION_MID: begin coef_a = A_MID; coef_b = B_MID; end
      default:    begin coef_a = A_HIGH; coef_b = B_HIGH; end
    endcase
  end

  assign flux_fl = (flux_r < FMIN) ? FMIN : flux_r;
  assign is_div  = (step_r == SP_FLUX) || (step_r == SP_IQ) || (step_r == SP_IDC);

  always_comb begin
    case (step_r)
      SP_KIDT:    begin op_a = ki;                    op_b = dt; end
      SP_SINT:    begin op_a = kidt_r;                op_b = err_r; end
      SP_TORQUE:  begin op_a = kp;                    op_b = err_r; end
      SP_FW_A:    begin op_a = coef_a;                op_b = tgt_r; end
      SP_FW_REF:  begin op_a = sub_s(coef_b, tmp_r);  op_b = nf; end
      SP_TAU_PHI: begin op_a = tau;                   op_b = rflux_r; end
      SP_DT_LM:   begin op_a = dt;                    op_b = lm; end
      SP_ID_TERM: begin op_a = id_r;                  op_b = tmp2_r; end
      SP_FLUX:    begin op_a = tmp_r;                 op_b = add_s(dt, tau); end
      SP_IQ_NUM:  begin op_a = add_s(lr, lr);         op_b = torque_r; end
      SP_LM12:    begin op_a = K12;                   op_b = lm; end
      SP_IQ_DEN:  begin op_a = tmp2_r;                op_b = flux_fl; end
      SP_IQ:      begin op_a = tmp_r;                 op_b = tmp2_r; end
      SP_FINT:    begin op_a = kidt_r;                op_b = sub_s(fref_r, flux_r); end
      SP_FSUM:    begin op_a = kp;                    op_b = sub_s(fref_r, flux_r); end
      default:    begin op_a = tmp_r;                 op_b = lm; end
    endcase
  end

  imvc_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_ISSUE && !is_div),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  imvc_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_ISSUE && is_div),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (div_res),
    .stat  (div_stat)
  );

  assign unit_done = is_div ? div_stat.done : mul_stat.done;
  assign res       = is_div ? div_res : mul_res;
  assign out_free  = !out_valid_r || out_pop;
  assign item_pop  = (state_r == ST_IDLE) && item_valid;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = ST_ISSUE;
          step_nxt  = SP_KIDT;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          if (step_r == SP_IDC) state_nxt = ST_OUT;
          else state_nxt = ST_ISSUE;
          // the base speed band needs no field-weakening products
          if (step_r == SP_TORQUE && region_r == REGION_BASE) step_nxt = SP_TAU_PHI;
          else step_nxt = step_r + 4'd1;
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_KIDT;
      out_valid_r <= 1'b0;
      sint_r      <= '0;
      fint_r      <= '0;
      rflux_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      if (state_r == ST_WAIT && unit_done) begin
        case (step_r)
          SP_SINT: sint_r  <= clamp_sym(add_s(sint_r, res), LIM15);
          SP_FINT: fint_r  <= clamp_sym(add_s(fint_r, res), LIM1);
          SP_IDC:  rflux_r <= flux_r;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      id_r     <= item_id;
      tgt_r    <= item_tgt;
      err_r    <= item_err;
      region_r <= item_region;
    end
    if (state_r == ST_WAIT && unit_done) begin
      case (step_r)
        SP_KIDT:    kidt_r   <= res;
        SP_TORQUE: begin
          torque_r <= clamp_sym(add_s(sint_r, res), tlim);
          if (region_r == REGION_BASE) fref_r <= nf;
        end
        SP_FW_A:    tmp_r    <= res;
        SP_FW_REF:  fref_r   <= res;
        SP_TAU_PHI: tmp_r    <= res;
        SP_DT_LM:   tmp2_r   <= res;
        SP_ID_TERM: tmp_r    <= add_s(tmp_r, res);
        SP_FLUX:    flux_r   <= res;
        SP_IQ_NUM:  tmp_r    <= res;
        SP_LM12:    tmp2_r   <= res;
        SP_IQ_DEN:  tmp2_r   <= res;
        SP_IQ:      iq_r     <= res;
        SP_FSUM:    tmp_r    <= clamp_sym(add_s(fint_r, res), LIM2);
        SP_IDC:     tmp2_r   <= res;
        default: ;
      endcase
    end
    if (state_r == ST_OUT && out_free) begin
      o_id_r <= tmp2_r;
      o_iq_r <= iq_r;
      o_tq_r <= torque_r;
      o_fl_r <= flux_r;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_id_command     = o_id_r;
  assign out_iq_command     = o_iq_r;
  assign out_torque_command = o_tq_r;
  assign out_rotor_flux_out = o_fl_r;

endmodule

`default_nettype wire

// ===== rtl/core/imvc_checker.sv =====
// Port-level checker for the vector control step block, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module imvc_checker #(
  parameter int DATA_WIDTH = 48
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_push,
  input wire logic                  in_full,
  input wire logic                  out_empty,
  input wire logic                  out_pop,
  input wire logic [DATA_WIDTH-1:0] out_id_command
);

  logic [2:0] pend_r;
  logic       acc_in, acc_out;

  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  // samples accepted and not yet returned
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 3'd0;
    else pend_r <= pend_r + {2'd0, acc_in} - {2'd0, acc_out};
  end

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 3'd0) |-> out_empty)
    else $error("result shown with no sample outstanding");

  a_bounded_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more samples held than queue and pipeline can store");

  a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (pend_r >= 3'd2))
    else $error("input reports full with fewer than two samples held");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_id_command)))
    else $error("waiting result changed before transfer");

endmodule

bind induction_motor_vector_control_step_top imvc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_id_command (out_id_command)
);

`default_nettype wire
